// File: rtl/core/hdac_pkg.sv
// Shared types, constants and elaboration-time helpers for the half/diff angle converter.
package hdac_pkg;

   localparam int VEC_W     = 34;
   localparam int ANG_W     = 35;
   localparam int GAIN_W    = 31;
   localparam int Q_SHIFT   = 30;
   localparam int STAGE_MAX = 24;

   typedef logic signed [VEC_W-1:0] vec_type;
   typedef logic signed [ANG_W-1:0] ang_type;

   localparam vec_type Q_ONE     = 34'sd1073741824;
   localparam ang_type Q_PI      = 35'sd3373259426;
   localparam ang_type Q_HALF_PI = 35'sd1686629713;
   localparam ang_type Q_TWO_PI  = 35'sd6746518852;

   localparam ang_type ATAN_Q30 [0:STAGE_MAX-1] = '{
      35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
      35'sd67021687,  35'sd33543516,  35'sd16775851,  35'sd8388437,
      35'sd4194283,   35'sd2097149,   35'sd1048576,   35'sd524288,
      35'sd262144,    35'sd131072,    35'sd65536,     35'sd32768,
      35'sd16384,     35'sd8192,      35'sd4096,      35'sd2048,
      35'sd1024,      35'sd512,       35'sd256,       35'sd128
   };

   // Gain compensation for n micro-rotations, round(2^30 / sqrt(prod(1 + 2^-2i))), in Q30.
   function automatic longint unsigned gain_q30(input int n);
      longint unsigned p;
      longint unsigned num;
      longint unsigned r;
      longint unsigned bitv;
      longint unsigned s;
      longint unsigned rem;
      longint unsigned q;
      p = 64'd1 << 30;
      for (int i = 0; i < STAGE_MAX; i++) begin
         if (i < n) begin
            p = p + (p >> (2 * i));
         end
      end
      // square root, two bits per step
      num  = p << 30;
      r    = 64'd0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (num >= r + bitv) begin
            num = num - (r + bitv);
            r   = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      s = r;
      // restoring long division of the rounded numerator by s
      num = (64'd1 << 60) + (s >> 1);
      rem = 64'd0;
      q   = 64'd0;
      for (int b = 63; b >= 0; b--) begin
         rem = (rem << 1) | longint'(num[b]);
         if (rem >= s) begin
            rem  = rem - s;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

endpackage

// File: rtl/core/hdac_rotate.sv
// Pipelined rotation CORDIC: turns (x, y) by an angle, one micro-rotation per stage.
module hdac_rotate #(
   parameter int STAGES = 16,
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  hdac_pkg::vec_type    in_x,
   input  hdac_pkg::vec_type    in_y,
   input  hdac_pkg::ang_type    in_angle,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output hdac_pkg::vec_type    out_x,
   output hdac_pkg::vec_type    out_y,
   output logic [SIDE_W-1:0]    out_side
);
   import hdac_pkg::*;

   localparam int N = (STAGES < STAGE_MAX) ? STAGES : STAGE_MAX;
   localparam logic signed [GAIN_W-1:0] GAIN = GAIN_W'(gain_q30(N));

   logic              valid_ff [0:N];
   vec_type           x_ff     [0:N];
   vec_type           y_ff     [0:N];
   ang_type           r_ff     [0:N];
   logic [SIDE_W-1:0] side_ff  [0:N];

   ang_type r_wrap;
   ang_type r_in;
   vec_type x_in;
   vec_type y_in;

   // Bring the angle into one turn, then fold it into the right half plane.
   always_comb begin
      r_wrap = in_angle;
      if (in_angle > Q_PI) begin
         r_wrap = in_angle - Q_TWO_PI;
      end else if (in_angle < -Q_PI) begin
         r_wrap = in_angle + Q_TWO_PI;
      end
      r_in = r_wrap;
      x_in = in_x;
      y_in = in_y;
      if (r_wrap > Q_HALF_PI) begin
         r_in = r_wrap - Q_PI;
         x_in = -in_x;
         y_in = -in_y;
      end else if (r_wrap < -Q_HALF_PI) begin
         r_in = r_wrap + Q_PI;
         x_in = -in_x;
         y_in = -in_y;
      end
   end

   always_ff @(posedge clock) begin
      valid_ff[0] <= reset ? 1'b0 : in_valid;
      x_ff[0]     <= x_in;
      y_ff[0]     <= y_in;
      r_ff[0]     <= r_in;
      side_ff[0]  <= in_side;
   end

   // Advance one micro-rotation per stage.
   for (genvar k = 0; k < N; k++) begin : g_stage
      vec_type dx;
      vec_type dy;
      assign dx = y_ff[k] >>> k;
      assign dy = x_ff[k] >>> k;
      always_ff @(posedge clock) begin
         valid_ff[k+1] <= reset ? 1'b0 : valid_ff[k];
         side_ff[k+1]  <= side_ff[k];
         if (r_ff[k] >= 0) begin
            x_ff[k+1] <= x_ff[k] - dx;
            y_ff[k+1] <= y_ff[k] + dy;
            r_ff[k+1] <= r_ff[k] - ATAN_Q30[k];
         end else begin
            x_ff[k+1] <= x_ff[k] + dx;
            y_ff[k+1] <= y_ff[k] - dy;
            r_ff[k+1] <= r_ff[k] + ATAN_Q30[k];
         end
      end
   end

   logic signed [VEC_W+GAIN_W-1:0] prod_x;
   logic signed [VEC_W+GAIN_W-1:0] prod_y;
   logic                           valid_out_ff;
   vec_type                        x_out_ff;
   vec_type                        y_out_ff;
   logic [SIDE_W-1:0]              side_out_ff;

   // Remove the CORDIC gain.
   assign prod_x = x_ff[N] * GAIN;
   assign prod_y = y_ff[N] * GAIN;

   always_ff @(posedge clock) begin
      valid_out_ff <= reset ? 1'b0 : valid_ff[N];
      x_out_ff     <= prod_x[Q_SHIFT +: VEC_W];
      y_out_ff     <= prod_y[Q_SHIFT +: VEC_W];
      side_out_ff  <= side_ff[N];
   end

   assign out_valid = valid_out_ff;
   assign out_x     = x_out_ff;
   assign out_y     = y_out_ff;
   assign out_side  = side_out_ff;

endmodule

// File: rtl/core/hdac_vector.sv
// Pipelined vectoring CORDIC: magnitude and atan2 of (x, y), one step per stage.
module hdac_vector #(
   parameter int STAGES = 16,
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  hdac_pkg::vec_type    in_x,
   input  hdac_pkg::vec_type    in_y,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output hdac_pkg::vec_type    out_mag,
   output hdac_pkg::ang_type    out_angle,
   output logic [SIDE_W-1:0]    out_side
);
   import hdac_pkg::*;

   localparam int N = (STAGES < STAGE_MAX) ? STAGES : STAGE_MAX;
   localparam logic signed [GAIN_W-1:0] GAIN = GAIN_W'(gain_q30(N));

   logic              valid_ff  [0:N];
   logic              bypass_ff [0:N];
   vec_type           x_ff      [0:N];
   vec_type           y_ff      [0:N];
   ang_type           z_ff      [0:N];
   ang_type           off_ff    [0:N];
   logic [SIDE_W-1:0] side_ff   [0:N];

   logic    bypass_in;
   vec_type x_in;
   vec_type y_in;
   ang_type z_in;
   ang_type off_in;

   // Zero y settles the result at once; negative x goes to the right half plane.
   always_comb begin
      bypass_in = 1'b0;
      x_in      = in_x;
      y_in      = in_y;
      z_in      = '0;
      off_in    = '0;
      if (in_y == 0) begin
         bypass_in = 1'b1;
         if (in_x < 0) begin
            x_in = -in_x;
            z_in = Q_PI;
         end
      end else if (in_x < 0) begin
         off_in = (in_y > 0) ? Q_PI : -Q_PI;
         x_in   = -in_x;
         y_in   = -in_y;
      end
   end

   always_ff @(posedge clock) begin
      valid_ff[0]  <= reset ? 1'b0 : in_valid;
      bypass_ff[0] <= bypass_in;
      x_ff[0]      <= x_in;
      y_ff[0]      <= y_in;
      z_ff[0]      <= z_in;
      off_ff[0]    <= off_in;
      side_ff[0]   <= in_side;
   end

   // Drive y toward zero, one step per stage; hold settled items.
   for (genvar k = 0; k < N; k++) begin : g_stage
      vec_type dx;
      vec_type dy;
      assign dx = y_ff[k] >>> k;
      assign dy = x_ff[k] >>> k;
      always_ff @(posedge clock) begin
         valid_ff[k+1]  <= reset ? 1'b0 : valid_ff[k];
         bypass_ff[k+1] <= bypass_ff[k];
         off_ff[k+1]    <= off_ff[k];
         side_ff[k+1]   <= side_ff[k];
         if (bypass_ff[k]) begin
            x_ff[k+1] <= x_ff[k];
            y_ff[k+1] <= y_ff[k];
            z_ff[k+1] <= z_ff[k];
         end else if (y_ff[k] > 0) begin
            x_ff[k+1] <= x_ff[k] + dx;
            y_ff[k+1] <= y_ff[k] - dy;
            z_ff[k+1] <= z_ff[k] + ATAN_Q30[k];
         end else begin
            x_ff[k+1] <= x_ff[k] - dx;
            y_ff[k+1] <= y_ff[k] + dy;
            z_ff[k+1] <= z_ff[k] - ATAN_Q30[k];
         end
      end
   end

   logic signed [VEC_W+GAIN_W-1:0] prod_x;
   ang_type                        z_sum;
   ang_type                        z_clamp;
   logic                           valid_out_ff;
   vec_type                        mag_out_ff;
   ang_type                        ang_out_ff;
   logic [SIDE_W-1:0]              side_out_ff;

   // Remove the gain, add the half-plane offset and clamp to plus/minus pi.
   assign prod_x = x_ff[N] * GAIN;
   always_comb begin
      z_sum   = z_ff[N] + off_ff[N];
      z_clamp = z_sum;
      if (z_sum > Q_PI) begin
         z_clamp = Q_PI;
      end else if (z_sum < -Q_PI) begin
         z_clamp = -Q_PI;
      end
   end

   always_ff @(posedge clock) begin
      valid_out_ff <= reset ? 1'b0 : valid_ff[N];
      mag_out_ff   <= bypass_ff[N] ? x_ff[N] : prod_x[Q_SHIFT +: VEC_W];
      ang_out_ff   <= z_clamp;
      side_out_ff  <= side_ff[N];
   end

   assign out_valid = valid_out_ff;
   assign out_mag   = mag_out_ff;
   assign out_angle = ang_out_ff;
   assign out_side  = side_out_ff;

endmodule

// File: rtl/core/half_diff_angle_conversion.sv
// Top level of the half/difference angle converter.
// A new direction pair may be started in every cycle; busy stays low. Each item
// passes seven CORDIC passes in a row (two to build the unit vectors, then
// halfway azimuth, halfway polar with the first rotation beside it, the second
// rotation, and two vectoring passes for the difference angles), each one
// registered at its input, after every micro-rotation and at its output, plus
// two register stages for the halfway vector and the rounded result. The
// result is shown for one cycle only and must be taken then. A zero halfway
// vector sets rsp_degenerate and returns all four angles as zero.
module half_diff_angle_conversion #(
   parameter int ANGLE_FRAC_BITS = 13,
   parameter int CORDIC_STAGES   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [14:0]        req_incoming_polar,
   input  logic signed [15:0] req_incoming_azimuth,
   input  logic [14:0]        req_outgoing_polar,
   input  logic signed [15:0] req_outgoing_azimuth,
   output logic               rsp_valid,
   output logic [14:0]        rsp_half_polar,
   output logic signed [15:0] rsp_half_azimuth,
   output logic [14:0]        rsp_diff_polar,
   output logic signed [15:0] rsp_diff_azimuth,
   output logic               rsp_degenerate
);
   import hdac_pkg::*;

   localparam int SCALE_SH = Q_SHIFT - ANGLE_FRAC_BITS;
   localparam int AZ_W     = 16;

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Scale port angles to internal radians.
   ang_type pol_i;
   ang_type pol_o;
   assign pol_i = ang_type'(req_incoming_polar) <<< SCALE_SH;
   assign pol_o = ang_type'(req_outgoing_polar) <<< SCALE_SH;

   // Polar rotation of the z axis for both directions.
   logic              v1;
   logic              v1o;
   vec_type           ct_i, st_i, ct_o, st_o;
   logic [AZ_W-1:0]   az_i1, az_o1;

   hdac_rotate #(.STAGES(CORDIC_STAGES), .SIDE_W(AZ_W)) u_pol_in (
      .clock, .reset, .in_valid(accept), .in_x(Q_ONE), .in_y('0), .in_angle(pol_i),
      .in_side(req_incoming_azimuth), .out_valid(v1), .out_x(ct_i), .out_y(st_i),
      .out_side(az_i1));
   hdac_rotate #(.STAGES(CORDIC_STAGES), .SIDE_W(AZ_W)) u_pol_out (
      .clock, .reset, .in_valid(accept), .in_x(Q_ONE), .in_y('0), .in_angle(pol_o),
      .in_side(req_outgoing_azimuth), .out_valid(v1o), .out_x(ct_o), .out_y(st_o),
      .out_side(az_o1));

   ang_type azi_i, azi_o;
   assign azi_i = ang_type'(signed'(az_i1)) <<< SCALE_SH;
   assign azi_o = ang_type'(signed'(az_o1)) <<< SCALE_SH;

   // Azimuth rotation finishes the unit vectors.
   logic    v2, v2o;
   vec_type vi0, vi1, vi2, vo0, vo1, vo2;

   hdac_rotate #(.STAGES(CORDIC_STAGES), .SIDE_W(VEC_W)) u_azi_in (
      .clock, .reset, .in_valid(v1), .in_x(st_i), .in_y('0), .in_angle(azi_i),
      .in_side(ct_i), .out_valid(v2), .out_x(vi0), .out_y(vi1), .out_side(vi2));
   hdac_rotate #(.STAGES(CORDIC_STAGES), .SIDE_W(VEC_W)) u_azi_out (
      .clock, .reset, .in_valid(v1o), .in_x(st_o), .in_y('0), .in_angle(azi_o),
      .in_side(ct_o), .out_valid(v2o), .out_x(vo0), .out_y(vo1), .out_side(vo2));

   // Form the halfway vector and flag its zero length.
   logic    h_valid_ff, deg_ff;
   vec_type hx_ff, hy_ff, hz_ff, vi0_ff, vi1_ff, vi2_ff;
   vec_type hx, hy, hz;
   assign hx = vi0 + vo0;
   assign hy = vi1 + vo1;
   assign hz = vi2 + vo2;

   always_ff @(posedge clock) begin
      h_valid_ff <= reset ? 1'b0 : (v2 && v2o);
      deg_ff     <= (hx == 0) && (hy == 0) && (hz == 0);
      hx_ff      <= hx;
      hy_ff      <= hy;
      hz_ff      <= hz;
      vi0_ff     <= vi0;
      vi1_ff     <= vi1;
      vi2_ff     <= vi2;
   end

   // Halfway azimuth and xy length.
   localparam int S3_W = 4 * VEC_W + 1;
   logic            v3;
   vec_type         rxy;
   ang_type         ph3;
   logic [S3_W-1:0] s3;
   hdac_vector #(.STAGES(CORDIC_STAGES), .SIDE_W(S3_W)) u_half_azi (
      .clock, .reset, .in_valid(h_valid_ff), .in_x(hx_ff), .in_y(hy_ff),
      .in_side({hz_ff, vi0_ff, vi1_ff, vi2_ff, deg_ff}),
      .out_valid(v3), .out_mag(rxy), .out_angle(ph3), .out_side(s3));

   vec_type hz3, vi0_3, vi1_3, vi2_3;
   logic    deg3;
   assign {hz3, vi0_3, vi1_3, vi2_3, deg3} = s3;

   // Halfway polar angle beside the turn about z by minus the half azimuth.
   localparam int S4_W = ANG_W + 1;
   logic            v4, v4r;
   vec_type         len4, tx, ty, vi2_4;
   ang_type         th4, ph4;
   logic            deg4;
   hdac_vector #(.STAGES(CORDIC_STAGES), .SIDE_W(S4_W)) u_half_pol (
      .clock, .reset, .in_valid(v3), .in_x(hz3), .in_y(rxy), .in_side({ph3, deg3}),
      .out_valid(v4), .out_mag(len4), .out_angle(th4), .out_side({ph4, deg4}));
   hdac_rotate #(.STAGES(CORDIC_STAGES), .SIDE_W(VEC_W)) u_turn_z (
      .clock, .reset, .in_valid(v3), .in_x(vi0_3), .in_y(vi1_3), .in_angle(-ph3),
      .in_side(vi2_3), .out_valid(v4r), .out_x(tx), .out_y(ty), .out_side(vi2_4));

   // Turn about y by minus the half polar angle.
   localparam int S5_W = VEC_W + 2 * ANG_W + 1;
   logic    v5;
   vec_type dz, dx, ty5;
   ang_type th5, ph5;
   logic    deg5;
   hdac_rotate #(.STAGES(CORDIC_STAGES), .SIDE_W(S5_W)) u_turn_y (
      .clock, .reset, .in_valid(v4 && v4r), .in_x(vi2_4), .in_y(tx), .in_angle(-th4),
      .in_side({ty, th4, ph4, deg4}), .out_valid(v5), .out_x(dz), .out_y(dx),
      .out_side({ty5, th5, ph5, deg5}));

   // Difference azimuth.
   logic    v6;
   vec_type rd, dz6;
   ang_type pd6, th6, ph6;
   logic    deg6;
   hdac_vector #(.STAGES(CORDIC_STAGES), .SIDE_W(S5_W)) u_diff_azi (
      .clock, .reset, .in_valid(v5), .in_x(dx), .in_y(ty5), .in_side({dz, th5, ph5, deg5}),
      .out_valid(v6), .out_mag(rd), .out_angle(pd6), .out_side({dz6, th6, ph6, deg6}));

   // Difference polar angle.
   localparam int S7_W = 3 * ANG_W + 1;
   logic    v7;
   vec_type len7;
   ang_type td7, pd7, th7, ph7;
   logic    deg7;
   hdac_vector #(.STAGES(CORDIC_STAGES), .SIDE_W(S7_W)) u_diff_pol (
      .clock, .reset, .in_valid(v6), .in_x(dz6), .in_y(rd), .in_side({pd6, th6, ph6, deg6}),
      .out_valid(v7), .out_mag(len7), .out_angle(td7), .out_side({pd7, th7, ph7, deg7}));

   // Round to port precision and saturate to each field.
   function automatic ang_type round_angle(input ang_type a);
      return (a + (ang_type'(1) <<< (SCALE_SH - 1))) >>> SCALE_SH;
   endfunction

   function automatic logic [14:0] sat_polar(input ang_type a);
      ang_type v;
      v = round_angle(a);
      if (v < 0) begin
         return '0;
      end else if (v > ang_type'(32767)) begin
         return 15'h7fff;
      end
      return v[14:0];
   endfunction

   function automatic logic [15:0] sat_azimuth(input ang_type a);
      ang_type v;
      v = round_angle(a);
      if (v < ang_type'(-32768)) begin
         return 16'h8000;
      end else if (v > ang_type'(32767)) begin
         return 16'h7fff;
      end
      return v[15:0];
   endfunction

   logic        rsp_valid_ff, deg_out_ff;
   logic [14:0] hp_ff, dp_ff;
   logic [15:0] ha_ff, da_ff;

   always_ff @(posedge clock) begin
      rsp_valid_ff <= reset ? 1'b0 : v7;
      deg_out_ff   <= deg7;
      hp_ff        <= deg7 ? '0 : sat_polar(th7);
      ha_ff        <= deg7 ? '0 : sat_azimuth(ph7);
      dp_ff        <= deg7 ? '0 : sat_polar(td7);
      da_ff        <= deg7 ? '0 : sat_azimuth(pd7);
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_degenerate   = deg_out_ff;
   assign rsp_half_polar   = hp_ff;
   assign rsp_half_azimuth = signed'(ha_ff);
   assign rsp_diff_polar   = dp_ff;
   assign rsp_diff_azimuth = signed'(da_ff);

   // The final magnitudes are not part of the result.
   logic unused_len;
   assign unused_len = ^{len4, len7};

endmodule

// File: rtl/core/hdac_checker.sv
// Port-level checks for the half/diff angle converter, bound to the top level.
module hdac_checker #(
   parameter int ANGLE_FRAC_BITS = 13
) (
   input logic               clock,
   input logic               reset,
   input logic               busy,
   input logic               rsp_valid,
   input logic [14:0]        rsp_half_polar,
   input logic signed [15:0] rsp_half_azimuth,
   input logic [14:0]        rsp_diff_polar,
   input logic signed [15:0] rsp_diff_azimuth,
   input logic               rsp_degenerate
);
   import hdac_pkg::*;

   localparam int     SH     = Q_SHIFT - ANGLE_FRAC_BITS;
   localparam longint PI_RAW = (longint'(Q_PI) + (64'sd1 <<< (SH - 1))) >>> SH;
   localparam longint PI_LIM = (PI_RAW > 32767) ? 32767 : PI_RAW;

   // A degenerate transfer carries zero angles.
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_half_polar == 0 && rsp_half_azimuth == 0 &&
      rsp_diff_polar == 0 && rsp_diff_azimuth == 0)
      else $error("degenerate result with nonzero angle");

   // Polar angles stay within zero to pi.
   a_polar_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> longint'(rsp_half_polar) <= PI_LIM && longint'(rsp_diff_polar) <= PI_LIM)
      else $error("polar angle beyond pi");

   // Azimuths stay within minus pi to pi.
   a_azimuth_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> longint'(rsp_half_azimuth) <= PI_LIM &&
      longint'(rsp_half_azimuth) >= -PI_LIM - 1 &&
      longint'(rsp_diff_azimuth) <= PI_LIM && longint'(rsp_diff_azimuth) >= -PI_LIM - 1)
      else $error("azimuth beyond pi");

   // Reset flushes the pipeline and the block never refuses a start.
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("result strobe or busy after reset");

endmodule

bind half_diff_angle_conversion hdac_checker #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_checker (
   .clock(clock), .reset(reset), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_half_polar(rsp_half_polar), .rsp_half_azimuth(rsp_half_azimuth),
   .rsp_diff_polar(rsp_diff_polar), .rsp_diff_azimuth(rsp_diff_azimuth),
   .rsp_degenerate(rsp_degenerate));

// File: sim/half_diff_angle_conversion_tb.sv
// Self-checking testbench for the half/difference angle converter.
`timescale 1ns / 100ps

module half_diff_angle_conversion_tb;
   import hdac_pkg::*;

   localparam int FRAC_BITS = 13;
   localparam int STAGES    = 16;
   localparam int LATENCY   = 7 * (STAGES + 2) + 2;
   localparam longint Q30_ONE = 64'sd1073741824;
   localparam longint RAD_PI  = 64'sd3373259426;
   localparam longint RAD_HPI = 64'sd1686629713;
   localparam longint RAD_2PI = 64'sd6746518852;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [14:0]        half_polar;
      logic signed [15:0] half_azimuth;
      logic [14:0]        diff_polar;
      logic signed [15:0] diff_azimuth;
      logic               degenerate;
   } angles_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [14:0]        req_incoming_polar   = '0;
   logic signed [15:0] req_incoming_azimuth = '0;
   logic [14:0]        req_outgoing_polar   = '0;
   logic signed [15:0] req_outgoing_azimuth = '0;
   logic               rsp_valid;
   logic [14:0]        rsp_half_polar;
   logic signed [15:0] rsp_half_azimuth;
   logic [14:0]        rsp_diff_polar;
   logic signed [15:0] rsp_diff_azimuth;
   logic               rsp_degenerate;

   angles_type expected_angles[$];
   int  failures = 0;
   int  transfers = 0;
   int  results_seen = 0;
   int  degenerate_seen = 0;
   int  cycles = 0;
   int  idle_pct = 0;
   longint gain_k;

   half_diff_angle_conversion #(.ANGLE_FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(STAGES)) dut (
      .clock, .reset, .start, .busy,
      .req_incoming_polar, .req_incoming_azimuth,
      .req_outgoing_polar, .req_outgoing_azimuth,
      .rsp_valid, .rsp_half_polar, .rsp_half_azimuth,
      .rsp_diff_polar, .rsp_diff_azimuth, .rsp_degenerate
   );

   always #2 clock = ~clock;

   // Floor shift for signed values.
   function automatic longint shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint compute_gain();
      longint unsigned p, n, r, b;
      p = 64'd1 << 30;
      for (int i = 0; i < STAGES; i++) p += p >> (2 * i);
      n = p << 30;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(((64'd1 << 60) + r / 2) / r);
   endfunction

   // Rotate (x,y) counterclockwise by angle a.
   task automatic rotate(input longint x, input longint y, input longint a,
                         output longint xo, output longint yo);
      longint r, dx, dy;
      r = a % RAD_2PI;
      if (r > RAD_PI) r -= RAD_2PI;
      if (r < -RAD_PI) r += RAD_2PI;
      if (r > RAD_HPI) begin
         r -= RAD_PI; x = -x; y = -y;
      end else if (r < -RAD_HPI) begin
         r += RAD_PI; x = -x; y = -y;
      end
      for (int i = 0; i < STAGES; i++) begin
         dx = shr(y, i);
         dy = shr(x, i);
         if (r >= 0) begin
            x -= dx; y += dy; r -= longint'(ATAN_Q30[i]);
         end else begin
            x += dx; y -= dy; r += longint'(ATAN_Q30[i]);
         end
      end
      xo = shr(x * gain_k, 30);
      yo = shr(y * gain_k, 30);
   endtask

   // Magnitude and atan2(y,x).
   task automatic vector(input longint x, input longint y,
                         output longint mag, output longint ang);
      longint off, z, dx, dy;
      off = 0;
      z = 0;
      if (y == 0) begin
         mag = x < 0 ? -x : x;
         ang = x < 0 ? RAD_PI : 0;
      end else begin
         if (x < 0) begin
            off = y > 0 ? RAD_PI : -RAD_PI;
            x = -x; y = -y;
         end
         for (int i = 0; i < STAGES; i++) begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (y > 0) begin
               x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
            end else begin
               x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
            end
         end
         z += off;
         if (z > RAD_PI) z = RAD_PI;
         if (z < -RAD_PI) z = -RAD_PI;
         mag = shr(x * gain_k, 30);
         ang = z;
      end
   endtask

   function automatic longint to_port(longint a, longint lo, longint hi);
      longint v;
      v = shr(a + (64'sd1 << (29 - FRAC_BITS)), 30 - FRAC_BITS);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

   task automatic direction(input logic [14:0] pol, input logic signed [15:0] azi,
                            output longint vx, output longint vy, output longint vz);
      longint ct, st;
      rotate(Q30_ONE, 0, longint'(pol) <<< (30 - FRAC_BITS), ct, st);
      rotate(st, 0, longint'(azi) <<< (30 - FRAC_BITS), vx, vy);
      vz = ct;
   endtask

   // Predict the half/difference angles of one direction pair.
   task automatic predict_angles(input logic [14:0] ip, input logic signed [15:0] ia,
                                 input logic [14:0] op, input logic signed [15:0] oa,
                                 output angles_type res);
      longint ix, iy, iz, ox, oy, oz, hx, hy, hz;
      longint rxy, len, th, ph, tx, ty, dz, dx, rd, td, pd;
      direction(ip, ia, ix, iy, iz);
      direction(op, oa, ox, oy, oz);
      hx = ix + ox; hy = iy + oy; hz = iz + oz;
      res = '0;
      if (hx == 0 && hy == 0 && hz == 0) begin
         res.degenerate = 1'b1;
      end else begin
         vector(hx, hy, rxy, ph);
         vector(hz, rxy, len, th);
         rotate(ix, iy, -ph, tx, ty);
         rotate(iz, tx, -th, dz, dx);
         vector(dx, ty, rd, pd);
         vector(dz, rd, len, td);
         res.half_polar   = 15'(to_port(th, 0, 32767));
         res.half_azimuth = 16'(to_port(ph, -32768, 32767));
         res.diff_polar   = 15'(to_port(td, 0, 32767));
         res.diff_azimuth = 16'(to_port(pd, -32768, 32767));
      end
   endtask

   // Drive one direction pair and wait for its transfer; start drops only on idle cycles.
   task automatic send_pair(input logic [14:0] ip, input logic signed [15:0] ia,
                            input logic [14:0] op, input logic signed [15:0] oa);
      angles_type res;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_incoming_polar <= ip;
      req_incoming_azimuth <= ia;
      req_outgoing_polar <= op;
      req_outgoing_azimuth <= oa;
      predict_angles(ip, ia, op, oa, res);
      do @(posedge clock); while (busy);
      expected_angles.insert(expected_angles.size(), res);
      transfers++;
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] rand_azimuth();
      return 16'($signed($urandom_range(51472)) - 25736);
   endfunction

   task automatic test_directed();
      send_pair(0, 0, 0, 0);
      send_pair(25736, 25736, 25736, -25736);
      send_pair(25736, 0, 0, 0);
      send_pair(0, 0, 25736, 0);
      send_pair(12868, 0, 12868, 25736);
      send_pair(12868, 12868, 12868, -12868);
      send_pair(15'h7fff, 16'sh7fff, 15'h7fff, -16'sh8000);
      send_pair(15'h7fff, -16'sh8000, 0, 16'sh7fff);
      send_pair(12868, 0, 12868, 0);
      send_pair(6434, -25736, 19302, 25736);
      send_pair(1, -1, 25735, 1);
      send_pair(12868, -12868, 12868, 12868);
      send_pair(20000, 3000, 5736, 3000 - 25736);
   endtask

   // Mostly in-range angles, some full-width, some mirrored pairs near degenerate.
   task automatic test_random(input int count, input int pct);
      logic [14:0] ip, op;
      logic signed [15:0] ia, oa;
      idle_pct = pct;
      repeat (count) begin
         case ($urandom_range(9))
            0: begin
               ip = 15'($urandom); ia = 16'($urandom);
               op = 15'($urandom); oa = 16'($urandom);
            end
            1: begin
               ip = 15'($urandom_range(25736)); ia = rand_azimuth();
               op = 15'(25736 - ip);
               oa = 16'(ia > 0 ? ia - 25736 : ia + 25736);
            end
            default: begin
               ip = 15'($urandom_range(25736)); ia = rand_azimuth();
               op = 15'($urandom_range(25736)); oa = rand_azimuth();
            end
         endcase
         send_pair(ip, ia, op, oa);
      end
   endtask

   // Compare each result with the oldest prediction.
   always @(posedge clock) begin
      angles_type want, got;
      cycles++;
      if (!reset && rsp_valid) begin
         got = {rsp_half_polar, rsp_half_azimuth, rsp_diff_polar,
                rsp_diff_azimuth, rsp_degenerate};
         results_seen++;
         if (rsp_degenerate) degenerate_seen++;
         if (expected_angles.size() == 0) begin
            failures++;
            $display("%0t: unexpected result %h", $time, got);
         end else begin
            want = expected_angles.pop_front();
            if (got.half_polar !== want.half_polar)
               $display("%0t: half_polar expected %0d actual %0d", $time,
                        want.half_polar, got.half_polar);
            if (got.half_azimuth !== want.half_azimuth)
               $display("%0t: half_azimuth expected %0d actual %0d", $time,
                        want.half_azimuth, got.half_azimuth);
            if (got.diff_polar !== want.diff_polar)
               $display("%0t: diff_polar expected %0d actual %0d", $time,
                        want.diff_polar, got.diff_polar);
            if (got.diff_azimuth !== want.diff_azimuth)
               $display("%0t: diff_azimuth expected %0d actual %0d", $time,
                        want.diff_azimuth, got.diff_azimuth);
            if (got.degenerate !== want.degenerate)
               $display("%0t: degenerate expected %0d actual %0d", $time,
                        want.degenerate, got.degenerate);
            if (got !== want) failures++;
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      int guard;
      gain_k = compute_gain();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(430, 28);
      test_random(430, 62);
      test_random(440, 0);
      start <= 1'b0;
      // drain, then allow for the pipeline depth
      guard = 0;
      while (expected_angles.size() != 0 && guard < 4 * LATENCY) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY + 8) @(posedge clock);
      if (expected_angles.size() != 0) begin
         failures++;
         $display("%0d predictions never arrived", expected_angles.size());
      end
      $display("Sent %0d direction pairs (directed, mirrored, full-width, random gaps);",
               transfers);
      $display("checked %0d results, %0d degenerate.", results_seen, degenerate_seen);
      if (failures == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
